FILE: hdl/atbs_pkg.sv
// Package for the modem bring-up sequencer: item types, status and phase codes,
// and the command table (timeouts and retry budgets).
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package atbs_pkg;

    // default configuration
    localparam int unsigned NUM_COMMANDS_DEF = 8;
    localparam int unsigned TIMER_BITS_DEF   = 14;

    // phase codes as reported on phase_now
    localparam logic [1:0] PHASE_SEND = 2'd0;
    localparam logic [1:0] PHASE_WAIT = 2'd1;
    localparam logic [1:0] PHASE_IDLE = 2'd2;

    // command outcome codes
    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_OK      = 2'd1,
        ST_ERR     = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    // command table indexes
    localparam logic [3:0] CMD_REBOOT = 4'd0;
    localparam logic [3:0] CMD_SERIAL = 4'd1;
    localparam logic [3:0] CMD_SIGNAL = 4'd2;
    localparam logic [3:0] CMD_ADDR   = 4'd3;
    localparam logic [3:0] CMD_SOCKET = 4'd4;

    // per-command timeouts in ticks
    localparam logic [13:0] TO_REBOOT  = 14'd10000;
    localparam logic [13:0] TO_SIGNAL  = 14'd3000;
    localparam logic [13:0] TO_DEFAULT = 14'd2000;

    // per-command retry budgets
    localparam logic [4:0] RETRY_REBOOT = 5'd3;
    localparam logic [4:0] RETRY_SERIAL = 5'd3;
    localparam logic [4:0] RETRY_SIGNAL = 5'd20;
    localparam logic [4:0] RETRY_ADDR   = 5'd10;
    localparam logic [4:0] RETRY_SOCKET = 5'd1;
    localparam logic [4:0] RETRY_NONE   = 5'd0;
    localparam logic [4:0] RETRY_MAX    = 5'd20;

    // response rule limits
    localparam logic [7:0] RSSI_MAX  = 8'd31;
    localparam logic [7:0] RSSI_ERR  = 8'd99;
    localparam logic [7:0] OCTET_MAX = 8'd254;

    typedef struct packed {
        logic       cmd;
        logic       marker_found;
        logic [7:0] signal_rssi;
        logic [7:0] bit_error_rate;
        logic [7:0] addr_octet_a;
        logic [7:0] addr_octet_b;
        logic [7:0] addr_octet_c;
        logic [7:0] addr_octet_d;
    } t_in_item;

    typedef struct packed {
        logic       send_valid;
        logic [2:0] send_index;
        logic [4:0] retries_remaining;
        logic [1:0] phase_now;
        logic [1:0] command_status;
        logic       sequence_done;
    } t_out_item;

    // which response rule applies to the current command
    typedef struct packed {
        logic is_signal;
        logic is_address;
    } t_rule_sel;

    function automatic logic [13:0] table_timeout(input logic [3:0] idx);
        logic [13:0] t;
        t = TO_DEFAULT;
        if (idx == CMD_REBOOT) begin
            t = TO_REBOOT;
        end else if (idx == CMD_SIGNAL) begin
            t = TO_SIGNAL;
        end
        return t;
    endfunction

    function automatic logic [4:0] table_retries(input logic [3:0] idx);
        logic [4:0] r;
        case (idx)
            CMD_REBOOT: r = RETRY_REBOOT;
            CMD_SERIAL: r = RETRY_SERIAL;
            CMD_SIGNAL: r = RETRY_SIGNAL;
            CMD_ADDR:   r = RETRY_ADDR;
            CMD_SOCKET: r = RETRY_SOCKET;
            default:    r = RETRY_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/atbs_if.sv
// Valid/ready channel interfaces for the sequencer's input and result items.
// Depends on atbs_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface atbs_item_if import atbs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface atbs_result_if import atbs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: hdl/at_command_bringup_sequencer_core.sv
// Modem bring-up sequencer: top level with input register, result register and
// the sequencer state. Depends on atbs_pkg, atbs_if and atbs_ctrl.
//
// Usage
// - i_item carries one item per handshake: a time tick (cmd = 0) or a
//   classified modem response (cmd = 1) with marker bit, signal values and
//   four address octets.
// - o_result gives exactly one result item per input item, in order: the
//   command issued (if any), the command index, the retry budget, the phase,
//   the outcome of the command that was current and a sequence-done flag.
// - An item is taken into the input register, and its result is registered in
//   the result register once that register is free or being drained.
// - One item per cycle while results are taken; the state update for an item
//   is a table lookup, a compare and a counter step between the two registers.
// - When the receiver stalls, the result register holds its item and the
//   input register takes one more item; ready drops only when both are full.
// - Reset (synchronous, active low) empties both registers and puts the
//   sequencer at the reboot command, send pending, with the reboot budget.
`timescale 1ns / 1ps
`default_nettype none

module at_command_bringup_sequencer_core
    import atbs_pkg::*;
#(
    parameter int unsigned NUM_COMMANDS = NUM_COMMANDS_DEF,
    parameter int unsigned TIMER_BITS   = TIMER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    atbs_item_if.sink     i_item,
    atbs_result_if.source o_result
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_accept;
    logic      w_step;
    t_out_item w_result;

    // an item moves on when the result register is free or being drained
    assign w_step       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_step;
    assign w_accept     = i_item.valid && i_item.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_item.item;
        end
    end

    atbs_ctrl #(
        .NUM_COMMANDS (NUM_COMMANDS),
        .TIMER_BITS   (TIMER_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.item  = r_out_item;

endmodule

`default_nettype wire

FILE: hdl/atbs_judge.sv
// Response rule check: turns a classified modem response into a command status.
// Depends on atbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atbs_judge
    import atbs_pkg::*;
(
    input  t_in_item  i_item_data,
    input  t_rule_sel i_sel,
    input  t_status   i_status,
    output t_status   o_status
);

    logic w_rssi_ok;
    logic w_rssi_err;
    logic w_addr_ok;

    // signal query: rssi 1..31 good, else 99 in either value is an error
    assign w_rssi_ok  = (i_item_data.signal_rssi != 8'd0) &&
                        (i_item_data.signal_rssi <= RSSI_MAX);
    assign w_rssi_err = (i_item_data.signal_rssi == RSSI_ERR) ||
                        (i_item_data.bit_error_rate == RSSI_ERR);

    // address query: first octet 1..253, the rest at most 254
    assign w_addr_ok = (i_item_data.addr_octet_a != 8'd0) &&
                       (i_item_data.addr_octet_a < OCTET_MAX) &&
                       (i_item_data.addr_octet_b <= OCTET_MAX) &&
                       (i_item_data.addr_octet_c <= OCTET_MAX) &&
                       (i_item_data.addr_octet_d <= OCTET_MAX);

    // no marker leaves the status alone
    always_comb begin
        o_status = i_status;
        if (i_item_data.marker_found) begin
            if (i_sel.is_signal) begin
                if (w_rssi_ok) begin
                    o_status = ST_OK;
                end else if (w_rssi_err) begin
                    o_status = ST_ERR;
                end
            end else if (i_sel.is_address) begin
                o_status = w_addr_ok ? ST_OK : ST_ERR;
            end else begin
                o_status = ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/atbs_ctrl.sv
// Sequencer state (phase, command index, retry budget, timer, status) and the
// next-state logic for one item. Depends on atbs_pkg and atbs_judge.
`timescale 1ns / 1ps
`default_nettype none

module atbs_ctrl
    import atbs_pkg::*;
#(
    parameter int unsigned NUM_COMMANDS = NUM_COMMANDS_DEF,
    parameter int unsigned TIMER_BITS   = TIMER_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int unsigned IDX_W = $clog2(NUM_COMMANDS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_COMMANDS - 1);
    localparam logic [23:0] TMR_MAX = 24'((64'd1 << TIMER_BITS) - 64'd1);

    typedef enum logic [1:0] {
        S_SEND = PHASE_SEND,
        S_WAIT = PHASE_WAIT,
        S_IDLE = PHASE_IDLE
    } t_phase;

    t_phase                r_phase;
    logic [IDX_W-1:0]      r_idx;
    logic [4:0]            r_budget;
    logic                  r_reload;
    logic [TIMER_BITS-1:0] r_timer;
    t_status               r_status;

    t_phase                n_phase;
    logic [IDX_W-1:0]      n_idx;
    logic [4:0]            n_budget;
    logic                  n_reload;
    logic [TIMER_BITS-1:0] n_timer;
    t_status               n_status;

    logic                  w_issue;
    t_status               w_reported;
    t_status               w_judged;
    t_rule_sel             w_sel;
    logic [IDX_W+2:0]      w_cur_ext;
    logic [IDX_W+2:0]      w_next_ext;

    // index zero-extended so table lookups see four bits at any depth
    function automatic logic [3:0] idx4(input logic [IDX_W-1:0] x);
        logic [IDX_W+2:0] e;
        e = {3'b000, x};
        return e[3:0];
    endfunction

    // table timeout saturated to the timer width
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [3:0] x);
        logic [23:0] raw;
        raw = 24'(table_timeout(x));
        if (raw > TMR_MAX) begin
            raw = TMR_MAX;
        end
        return raw[TIMER_BITS-1:0];
    endfunction

    // rule selection from the current command
    assign w_cur_ext        = {3'b000, r_idx};
    assign w_sel.is_signal  = (w_cur_ext[3:0] == CMD_SIGNAL) &&
                              (w_cur_ext[IDX_W+2:3] == '0);
    assign w_sel.is_address = (w_cur_ext[3:0] == CMD_ADDR) &&
                              (w_cur_ext[IDX_W+2:3] == '0);

    atbs_judge u_judge (
        .i_item_data (i_item),
        .i_sel       (w_sel),
        .i_status    (r_status),
        .o_status    (w_judged)
    );

    // next state for one item
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_budget   = r_budget;
        n_reload   = r_reload;
        n_timer    = r_timer;
        n_status   = r_status;
        w_issue    = 1'b0;
        w_reported = r_status;
        unique case (r_phase)
            S_SEND: begin
                w_issue = 1'b1;
            end
            S_WAIT: begin
                if (i_item.cmd) begin
                    n_status   = w_judged;
                    w_reported = w_judged;
                    if (w_judged == ST_OK) begin
                        if (r_idx == IDX_LAST) begin
                            n_phase = S_IDLE;
                        end else begin
                            n_idx    = r_idx + 1'b1;
                            n_reload = 1'b1;
                            w_issue  = 1'b1;
                        end
                    end
                end else if (r_timer <= TIMER_BITS'(1)) begin
                    n_timer    = '0;
                    n_status   = ST_TIMEOUT;
                    w_reported = ST_TIMEOUT;
                    if (r_budget != 5'd0) begin
                        n_budget = r_budget - 1'b1;
                        n_reload = 1'b0;
                        w_issue  = 1'b1;
                    end else begin
                        n_idx    = '0;
                        n_phase  = S_SEND;
                        n_reload = 1'b1;
                    end
                end else begin
                    n_timer = r_timer - 1'b1;
                end
            end
            S_IDLE: begin
                n_phase = S_IDLE;
            end
            default: begin
                n_phase = S_SEND;
            end
        endcase

        // issue the command now selected
        if (w_issue) begin
            if (n_reload) begin
                n_budget = table_retries(idx4(n_idx));
                n_reload = 1'b0;
            end
            n_timer  = timer_load(idx4(n_idx));
            n_status = ST_NONE;
            n_phase  = S_WAIT;
        end
    end

    // result for this item
    assign w_next_ext = {3'b000, n_idx};
    always_comb begin
        o_result.send_valid        = w_issue;
        o_result.send_index        = w_next_ext[2:0];
        o_result.retries_remaining = n_budget;
        o_result.phase_now         = n_phase;
        o_result.command_status    = w_reported;
        o_result.sequence_done     = (n_phase == S_IDLE);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= S_SEND;
            r_idx    <= '0;
            r_budget <= RETRY_REBOOT;
            r_reload <= 1'b1;
            r_timer  <= '0;
            r_status <= ST_NONE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_budget <= n_budget;
            r_reload <= n_reload;
            r_timer  <= n_timer;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/atbs_checker.sv
// Port-level checks for the modem bring-up sequencer, bound to the top level.
// Depends on atbs_pkg and at_command_bringup_sequencer_core.
`timescale 1ns / 1ps
`default_nettype none

module atbs_checker
    import atbs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    // a stalled result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)))
        else $error("result item changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // with no result waiting the block always takes an item
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with empty result register");

    // an issued command always leaves the block waiting, with budget at most RETRY_MAX
    a_send_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_item.send_valid) |->
            (i_out_item.phase_now == PHASE_WAIT &&
             i_out_item.retries_remaining <= RETRY_MAX))
        else $error("command issued without waiting phase");

    // done flag matches the idle phase
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_item.sequence_done == (i_out_item.phase_now == PHASE_IDLE)))
        else $error("sequence_done disagrees with phase");

endmodule

bind at_command_bringup_sequencer_core atbs_checker u_atbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_item  (o_result.item)
);

`default_nettype wire
